@@ hdl/xbr_pkg.sv @@
// ----------------------------------------------------------------------------
// xbr_pkg: shared types and constants for the bounded random generator
// Field widths, operation codes, generator reset words and mixer constants.
// ----------------------------------------------------------------------------
package xbr_pkg;

  localparam int unsigned FUNC_W = 3;
  localparam int unsigned WORD_W = 64;
  localparam int unsigned INT_W  = 32;

  typedef logic [FUNC_W-1:0]        func_t;
  typedef logic [WORD_W-1:0]        word_t;
  typedef logic signed [INT_W-1:0]  sint_t;

  // operation codes
  localparam func_t FN_SEED   = 3'd0;
  localparam func_t FN_RAW    = 3'd1;
  localparam func_t FN_RANGE  = 3'd2;
  localparam func_t FN_CHOICE = 3'd3;
  localparam func_t FN_FRAC   = 3'd4;

  // splitmix64 constants
  localparam word_t MIX_GOLDEN = 64'h9e3779b97f4a7c15;
  localparam word_t MIX_MUL1   = 64'hbf58476d1ce4e5b9;
  localparam word_t MIX_MUL2   = 64'h94d049bb133111eb;

  // generator state after reset
  localparam word_t GEN_RST0 = 64'h243f6a8885a308d3;
  localparam word_t GEN_RST1 = 64'h13198a2e03707344;
  localparam word_t GEN_RST2 = 64'ha4093822299f31d0;
  localparam word_t GEN_RST3 = 64'h082efa98ec4e6c89;

  localparam int unsigned GEN_ROT   = 45;
  localparam int unsigned GEN_SHIFT = 17;

endpackage

@@ hdl/xbr_ifs.sv @@
// ----------------------------------------------------------------------------
// xbr channel interfaces
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface xbr_in_if;
  logic            valid;
  logic            ready;
  xbr_pkg::func_t  func;
  xbr_pkg::word_t  seed_value;
  xbr_pkg::sint_t  range_min;
  xbr_pkg::sint_t  range_max;
  xbr_pkg::sint_t  choice_count;

  modport source (output valid, func, seed_value, range_min, range_max, choice_count,
                  input ready);
  modport sink   (input valid, func, seed_value, range_min, range_max, choice_count,
                  output ready);
endinterface

interface xbr_out_if;
  logic            valid;
  logic            ready;
  xbr_pkg::word_t  raw_value;
  xbr_pkg::sint_t  int_value;

  modport source (output valid, raw_value, int_value, input ready);
  modport sink   (input valid, raw_value, int_value, output ready);
endinterface

@@ hdl/xoshiro256ss_bounded_random.sv @@
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_random: xoshiro256** generator with bounded draws
// Seeding via splitmix64, raw and fractional outputs, unbiased range draws.
// ----------------------------------------------------------------------------
// One request word at a time: the block takes a word only when its sequencer
// is idle and returns exactly one result word for it. Raw and fraction draws
// run one generator step plus the output scrambler. A seed builds each of the
// four splitmix64 words from two 64x64 products, built from three 32x32
// partial products on a single shared multiplier. Range and choice draws use
// the bit-serial remainder unit, which runs once for the rejection threshold
// and again for the final remainder; each rejected draw repeats the generator
// step. A zero range bound and a nonpositive choice count finish without a
// draw. A finished result sits in an output register until it is taken; the
// next request is taken once that result has been loaded there.
module xoshiro256ss_bounded_random (
  input  logic clk,
  input  logic rst_n,
  xbr_in_if.sink    in_ch,
  xbr_out_if.source out_ch
);
  import xbr_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'b00000000000001,
    S_PREP     = 14'b00000000000010,
    S_BND_CHK  = 14'b00000000000100,
    S_DIV      = 14'b00000000001000,
    S_SUM      = 14'b00000000010000,
    S_MIX_ADD  = 14'b00000000100000,
    S_MIX_XS   = 14'b00000001000000,
    S_MUL      = 14'b00000010000000,
    S_MIX_FIN  = 14'b00000100000000,
    S_SEED_CHK = 14'b00001000000000,
    S_GEN_A    = 14'b00010000000000,
    S_GEN_B    = 14'b00100000000000,
    S_DRAW     = 14'b01000000000000,
    S_FIN      = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // captured request
  func_t         func_r, func_nxt;
  word_t         seed_r, seed_nxt;
  sint_t         min_r, min_nxt;
  sint_t         max_r, max_nxt;
  sint_t         cnt_in_r, cnt_in_nxt;

  // generator state
  word_t         gw_r [4];
  word_t         gw_nxt [4];

  // splitmix datapath
  word_t         acc_r, acc_nxt;       // splitmix running sum
  word_t         z_r, z_nxt;           // value being mixed
  word_t         pacc_r, pacc_nxt;     // partial product accumulator
  word_t         mp_r, mp_nxt;         // registered multiplier output
  logic [1:0]    mul_cnt_r, mul_cnt_nxt;
  logic          mix_ph_r, mix_ph_nxt; // 0: first multiply, 1: second
  logic [1:0]    widx_r, widx_nxt;

  // generator output datapath
  word_t         x5_r, x5_nxt;
  word_t         gres_r, gres_nxt;

  // bounded draw
  logic [31:0]   lo_r, lo_nxt;
  logic [31:0]   bound_r, bound_nxt;
  logic [31:0]   thresh_r, thresh_nxt;
  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   dvd_r, dvd_nxt;
  logic [4:0]    div_cnt_r, div_cnt_nxt;
  logic          div_final_r, div_final_nxt;

  // result
  word_t         raw_res_r, raw_res_nxt;
  logic [31:0]   int_res_r, int_res_nxt;
  logic          out_valid_r, out_valid_nxt;
  word_t         out_raw_r, out_raw_nxt;
  logic [31:0]   out_int_r, out_int_nxt;

  // shared combinational helpers
  logic [31:0]   mul_a, mul_b;
  word_t         mix_k;
  word_t         mix_sum;
  logic [32:0]   div_sh;
  logic [32:0]   div_diff;
  logic [31:0]   div_rem;
  word_t         rot7;
  logic [31:0]   span_fwd, span_rev;

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.raw_value = out_raw_r;
  assign out_ch.int_value = out_int_r;

  // shared 32x32 multiplier, operands picked by partial-product step
  always_comb begin
    mix_k = mix_ph_r ? MIX_MUL2 : MIX_MUL1;
    unique case (mul_cnt_r)
      2'd0:    begin mul_a = z_r[31:0];  mul_b = mix_k[31:0];  end
      2'd1:    begin mul_a = z_r[31:0];  mul_b = mix_k[63:32]; end
      2'd2:    begin mul_a = z_r[63:32]; mul_b = mix_k[31:0];  end
      default: begin mul_a = '0;         mul_b = '0;           end
    endcase
  end

  assign mp_nxt = word_t'(mul_a) * word_t'(mul_b);

  // restoring remainder step, one dividend bit per cycle
  assign div_sh   = {rem_r, dvd_r[31]};
  assign div_diff = div_sh - {1'b0, bound_r};
  assign div_rem  = div_diff[32] ? div_sh[31:0] : div_diff[31:0];

  assign mix_sum  = acc_r + MIX_GOLDEN;
  assign rot7     = {x5_r[56:0], x5_r[63:57]};
  assign span_fwd = 32'(max_r) - 32'(min_r) + 32'd1;
  assign span_rev = 32'(min_r) - 32'(max_r) + 32'd1;

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    seed_nxt      = seed_r;
    min_nxt       = min_r;
    max_nxt       = max_r;
    cnt_in_nxt    = cnt_in_r;
    for (int i = 0; i < 4; i++) gw_nxt[i] = gw_r[i];
    acc_nxt       = acc_r;
    z_nxt         = z_r;
    pacc_nxt      = pacc_r;
    mul_cnt_nxt   = mul_cnt_r;
    mix_ph_nxt    = mix_ph_r;
    widx_nxt      = widx_r;
    x5_nxt        = x5_r;
    gres_nxt      = gres_r;
    lo_nxt        = lo_r;
    bound_nxt     = bound_r;
    thresh_nxt    = thresh_r;
    rem_nxt       = rem_r;
    dvd_nxt       = dvd_r;
    div_cnt_nxt   = div_cnt_r;
    div_final_nxt = div_final_r;
    raw_res_nxt   = raw_res_r;
    int_res_nxt   = int_res_r;
    out_raw_nxt   = out_raw_r;
    out_int_nxt   = out_int_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          func_nxt   = in_ch.func;
          seed_nxt   = in_ch.seed_value;
          min_nxt    = in_ch.range_min;
          max_nxt    = in_ch.range_max;
          cnt_in_nxt = in_ch.choice_count;
          state_nxt  = S_PREP;
        end
      end

      S_PREP: begin
        raw_res_nxt = '0;
        int_res_nxt = '0;
        case (func_r)
          FN_SEED: begin
            acc_nxt    = seed_r;
            widx_nxt   = '0;
            mix_ph_nxt = 1'b0;
            state_nxt  = S_MIX_ADD;
          end
          FN_RAW, FN_FRAC: state_nxt = S_GEN_A;
          FN_RANGE: begin
            // reversed limits are swapped
            if (max_r < min_r) begin
              lo_nxt    = 32'(max_r);
              bound_nxt = span_rev;
            end else begin
              lo_nxt    = 32'(min_r);
              bound_nxt = span_fwd;
            end
            state_nxt = S_BND_CHK;
          end
          FN_CHOICE: begin
            lo_nxt = '0;
            if (cnt_in_r[31] || (cnt_in_r == '0)) begin
              int_res_nxt = '1;
              state_nxt   = S_FIN;
            end else begin
              bound_nxt = 32'(cnt_in_r);
              state_nxt = S_BND_CHK;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end

      S_BND_CHK: begin
        // full 32-bit range: bound wraps to zero, no draw
        if (bound_r == '0) begin
          int_res_nxt = lo_r;
          state_nxt   = S_FIN;
        end else begin
          rem_nxt       = '0;
          dvd_nxt       = 32'd0 - bound_r;
          div_cnt_nxt   = '0;
          div_final_nxt = 1'b0;
          state_nxt     = S_DIV;
        end
      end

      S_DIV: begin
        rem_nxt     = div_rem;
        dvd_nxt     = {dvd_r[30:0], 1'b0};
        div_cnt_nxt = div_cnt_r + 5'd1;
        if (div_cnt_r == '1) begin
          if (div_final_r) begin
            state_nxt = S_SUM;
          end else begin
            thresh_nxt = div_rem;
            state_nxt  = S_GEN_A;
          end
        end
      end

      S_SUM: begin
        int_res_nxt = lo_r + rem_r;
        state_nxt   = S_FIN;
      end

      S_MIX_ADD: begin
        acc_nxt   = mix_sum;
        z_nxt     = mix_sum;
        state_nxt = S_MIX_XS;
      end

      S_MIX_XS: begin
        z_nxt       = mix_ph_r ? (z_r ^ (z_r >> 27)) : (z_r ^ (z_r >> 30));
        mul_cnt_nxt = '0;
        state_nxt   = S_MUL;
      end

      S_MUL: begin
        // low 64 bits of z*k from three 32x32 partial products
        mul_cnt_nxt = mul_cnt_r + 2'd1;
        unique case (mul_cnt_r)
          2'd0: ;
          2'd1: pacc_nxt = mp_r;
          2'd2: pacc_nxt = {pacc_r[63:32] + mp_r[31:0], pacc_r[31:0]};
          default: begin
            z_nxt = {pacc_r[63:32] + mp_r[31:0], pacc_r[31:0]};
            if (mix_ph_r) begin
              state_nxt = S_MIX_FIN;
            end else begin
              mix_ph_nxt = 1'b1;
              state_nxt  = S_MIX_XS;
            end
          end
        endcase
      end

      S_MIX_FIN: begin
        gw_nxt[widx_r] = z_r ^ (z_r >> 31);
        if (widx_r == 2'd3) begin
          state_nxt = S_SEED_CHK;
        end else begin
          widx_nxt   = widx_r + 2'd1;
          mix_ph_nxt = 1'b0;
          state_nxt  = S_MIX_ADD;
        end
      end

      S_SEED_CHK: begin
        if ((gw_r[0] | gw_r[1] | gw_r[2] | gw_r[3]) == '0) gw_nxt[0] = 64'd1;
        state_nxt = S_FIN;
      end

      S_GEN_A: begin
        // scrambler input from the old word 1, state advance in parallel
        x5_nxt    = gw_r[1] + (gw_r[1] << 2);
        gw_nxt[2] = gw_r[2] ^ gw_r[0] ^ (gw_r[1] << GEN_SHIFT);
        gw_nxt[3] = {(gw_r[3] ^ gw_r[1]) << GEN_ROT}
                    | ((gw_r[3] ^ gw_r[1]) >> (WORD_W - GEN_ROT));
        gw_nxt[1] = gw_r[1] ^ gw_r[2] ^ gw_r[0];
        gw_nxt[0] = gw_r[0] ^ gw_r[3] ^ gw_r[1];
        state_nxt = S_GEN_B;
      end

      S_GEN_B: begin
        gres_nxt  = rot7 + (rot7 << 3);
        state_nxt = S_DRAW;
      end

      S_DRAW: begin
        if (func_r == FN_RAW) begin
          raw_res_nxt = gres_r;
          state_nxt   = S_FIN;
        end else if (func_r == FN_FRAC) begin
          raw_res_nxt = gres_r >> 11;
          state_nxt   = S_FIN;
        end else if (gres_r[63:32] >= thresh_r) begin
          rem_nxt       = '0;
          dvd_nxt       = gres_r[63:32];
          div_cnt_nxt   = '0;
          div_final_nxt = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          // rejected, draw again
          state_nxt = S_GEN_A;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_raw_nxt   = raw_res_r;
          out_int_nxt   = int_res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      gw_r[0]     <= GEN_RST0;
      gw_r[1]     <= GEN_RST1;
      gw_r[2]     <= GEN_RST2;
      gw_r[3]     <= GEN_RST3;
      mul_cnt_r   <= '0;
      mix_ph_r    <= 1'b0;
      widx_r      <= '0;
      div_cnt_r   <= '0;
      div_final_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < 4; i++) gw_r[i] <= gw_nxt[i];
      mul_cnt_r   <= mul_cnt_nxt;
      mix_ph_r    <= mix_ph_nxt;
      widx_r      <= widx_nxt;
      div_cnt_r   <= div_cnt_nxt;
      div_final_r <= div_final_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    seed_r    <= seed_nxt;
    min_r     <= min_nxt;
    max_r     <= max_nxt;
    cnt_in_r  <= cnt_in_nxt;
    acc_r     <= acc_nxt;
    z_r       <= z_nxt;
    pacc_r    <= pacc_nxt;
    mp_r      <= mp_nxt;
    x5_r      <= x5_nxt;
    gres_r    <= gres_nxt;
    lo_r      <= lo_nxt;
    bound_r   <= bound_nxt;
    thresh_r  <= thresh_nxt;
    rem_r     <= rem_nxt;
    dvd_r     <= dvd_nxt;
    raw_res_r <= raw_res_nxt;
    int_res_r <= int_res_nxt;
    out_raw_r <= out_raw_nxt;
    out_int_r <= out_int_nxt;
  end

  // an accepted word always starts the sequencer
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (state_r == S_PREP))
    else $error("accepted word did not start the sequencer");

  // generator never rests in the all-zero state
  a_state_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ((gw_r[0] | gw_r[1] | gw_r[2] | gw_r[3]) != '0))
    else $error("generator state is all zero");

  // remainder unit only runs with a nonzero bound
  a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (bound_r != '0))
    else $error("remainder step with zero bound");

  // a new result only comes from the finish state
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result loaded outside finish state");

endmodule

@@ tb/sv/xoshiro256ss_bounded_random_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// xoshiro256ss_bounded_random_test: self-checking bench for the bounded generator
// Drives request words through the valid/ready input channel and keeps its own
// model of the xoshiro256** state. Every result word is compared field by field
// with the model's prediction: directed edge cases first, then a long random mix,
// with random idle cycles on both channels.
// ----------------------------------------------------------------------------
module xoshiro256ss_bounded_random_test;
  import xbr_pkg::*;

  // codes the block does not use; they must leave the state alone
  localparam func_t FN_UNUSED_FIRST = 3'd5;
  localparam func_t FN_UNUSED_LAST  = 3'd7;

  localparam int unsigned RANDOM_WORDS = 1675;
  localparam int unsigned DRAIN_LIMIT  = 20000;  // cycles to wait for stragglers
  localparam int unsigned TAIL_CYCLES  = 100;    // quiet time after the last result
  localparam int unsigned IDLE_PCT     = 12;     // idle/stall rate per side

  typedef struct packed {
    func_t func;
    word_t seed_value;
    sint_t range_min;
    sint_t range_max;
    sint_t choice_count;
  } req_t;

  typedef struct packed {
    word_t raw_value;
    sint_t int_value;
  } result_t;

  logic clk = 1'b0;
  logic rst_n;

  xbr_in_if  in_ch ();
  xbr_out_if out_ch ();

  xoshiro256ss_bounded_random dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // model of the generator state, updated as each request word is accepted
  word_t   gen_model [4];
  // predicted result words, oldest first
  result_t pending_results [$];

  int error_count  = 0;
  int results_seen = 0;
  int ops_sent [8];
  bit idle_en = 1'b1;  // cleared for the long stretch without gaps or stalls

  // --------------------------------------------------------------------------
  // Generator model
  // --------------------------------------------------------------------------
  function automatic word_t rotl(input word_t v, input int unsigned k);
    return (v << k) | (v >> (64 - k));
  endfunction

  // one xoshiro256** step: returns the scrambled output, updates the state
  function automatic word_t next_word();
    word_t res, t;
    res = rotl(gen_model[1] * 64'd5, 7) * 64'd9;
    t   = gen_model[1] << GEN_SHIFT;
    gen_model[2] ^= gen_model[0];
    gen_model[3] ^= gen_model[1];
    gen_model[1] ^= gen_model[2];
    gen_model[0] ^= gen_model[3];
    gen_model[2] ^= t;
    gen_model[3] = rotl(gen_model[3], GEN_ROT);
    return res;
  endfunction

  // splitmix64 fill; an all-zero state is not allowed, word 0 becomes 1
  function automatic void seed_model(input word_t seed);
    word_t acc, z;
    acc = seed;
    for (int i = 0; i < 4; i++) begin
      acc += MIX_GOLDEN;
      z = acc;
      z = (z ^ (z >> 30)) * MIX_MUL1;
      z = (z ^ (z >> 27)) * MIX_MUL2;
      gen_model[i] = z ^ (z >> 31);
    end
    if ((gen_model[0] | gen_model[1] | gen_model[2] | gen_model[3]) == '0)
      gen_model[0] = 64'd1;
  endfunction

  // unbiased draw below bound: reject upper halves under (2^32 - bound) % bound
  function automatic logic [31:0] draw_below(input logic [31:0] bound);
    logic [31:0] thresh, v;
    word_t w;
    if (bound == 32'd0)
      return 32'd0;
    thresh = (32'd0 - bound) % bound;
    do begin
      w = next_word();
      v = w[63:32];
    end while (v < thresh);
    return v % bound;
  endfunction

  function automatic result_t predict_result(input req_t r);
    result_t res;
    sint_t lo, hi;
    logic [31:0] span;
    res = '0;
    case (r.func)
      FN_SEED:   seed_model(r.seed_value);
      FN_RAW:    res.raw_value = next_word();
      FN_FRAC:   res.raw_value = next_word() >> 11;
      FN_RANGE: begin
        lo = r.range_min;
        hi = r.range_max;
        if (hi < lo) begin
          lo = r.range_max;
          hi = r.range_min;
        end
        // full 32-bit range wraps the span to 0 and draws nothing
        span = $unsigned(hi) - $unsigned(lo) + 32'd1;
        res.int_value = $unsigned(lo) + draw_below(span);
      end
      FN_CHOICE: begin
        if (r.choice_count <= 0)
          res.int_value = -32'sd1;
        else
          res.int_value = draw_below($unsigned(r.choice_count));
      end
      default: ;  // unused codes: state untouched, both fields zero
    endcase
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Every field carries random noise; the caller overrides what matters.
  function automatic req_t make_req(input func_t f);
    req_t r;
    r.func         = f;
    r.seed_value   = {$urandom, $urandom};
    r.range_min    = $urandom;
    r.range_max    = $urandom;
    r.choice_count = $urandom;
    return r;
  endfunction

  // Presents one request word and waits for the handshake. valid is left high
  // so back-to-back words need no dead cycle; an idle gap lowers it first.
  task automatic send_word(input req_t r);
    if (idle_en && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 50);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= r.func;
    in_ch.seed_value   <= r.seed_value;
    in_ch.range_min    <= r.range_min;
    in_ch.range_max    <= r.range_max;
    in_ch.choice_count <= r.choice_count;
    do @(posedge clk); while (!in_ch.ready);
    // word taken at this edge: advance the model in acceptance order
    pending_results.push_back(predict_result(r));
    ops_sent[r.func]++;
  endtask

  task automatic send_range(input sint_t lo, input sint_t hi);
    req_t r;
    r = make_req(FN_RANGE);
    r.range_min = lo;
    r.range_max = hi;
    send_word(r);
  endtask

  task automatic send_choice(input sint_t n);
    req_t r;
    r = make_req(FN_CHOICE);
    r.choice_count = n;
    send_word(r);
  endtask

  task automatic send_seed(input word_t s);
    req_t r;
    r = make_req(FN_SEED);
    r.seed_value = s;
    send_word(r);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on ready, every taken word checked in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_results.size() == 0) begin
          $error("result word with nothing pending: raw_value %h int_value %0d",
                 out_ch.raw_value, out_ch.int_value);
          error_count++;
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          if (out_ch.raw_value !== want.raw_value) begin
            $error("raw_value mismatch: expected %h, actual %h",
                   want.raw_value, out_ch.raw_value);
            error_count++;
          end
          if (out_ch.int_value !== want.int_value) begin
            $error("int_value mismatch: expected %0d, actual %0d",
                   want.int_value, out_ch.int_value);
            error_count++;
          end
        end
      end
      out_ch.ready <= !(idle_en && $urandom_range(99) < IDLE_PCT);
    end else begin
      out_ch.ready <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Draws straight from the reset state, before any seed.
  task automatic test_reset_draws();
    send_word(make_req(FN_RAW));
    send_word(make_req(FN_FRAC));
    send_word(make_req(FN_RAW));
  endtask

  // Seed extremes, each followed by a draw to expose the new state.
  task automatic test_seed_extremes();
    send_seed('0);
    send_word(make_req(FN_RAW));
    send_seed('1);
    send_word(make_req(FN_FRAC));
    send_seed({1'b1, 63'd0});
    send_word(make_req(FN_RAW));
  endtask

  task automatic test_range_edges();
    send_range(32'sd5, 32'sd5);                   // bound of one
    send_range(32'sd10, -32'sd10);                // reversed limits
    send_range(32'sh8000_0000, 32'sh7fff_ffff);   // full range, zero bound
    send_range(32'sh7fff_ffff, 32'sh8000_0000);   // full range, reversed
    send_range(32'sh8000_0000, 32'sh8000_0000);
    send_range(32'sh7fff_ffff, 32'sh7fff_ffff);
    send_range(-32'sd1, 32'sh7fff_ffff);          // bound 2^31+1, heavy rejection
    send_range(32'sd0, 32'sh7fff_ffff);           // bound 2^31
  endtask

  task automatic test_choice_edges();
    send_choice(32'sd0);
    send_choice(-32'sd1);
    send_choice(32'sh8000_0000);
    send_choice(32'sd1);
    send_choice(32'sh7fff_ffff);
    send_choice(32'sd3);
  endtask

  // Unused codes answer zeros and must not disturb the state; the raw draw
  // after them proves that.
  task automatic test_unused_codes();
    for (int f = FN_UNUSED_FIRST; f <= FN_UNUSED_LAST; f++)
      send_word(make_req(func_t'(f)));
    send_word(make_req(FN_RAW));
  endtask

  // Weighted mix of all codes. Ranges and counts lean toward small bounds,
  // with full random values for wrap, reversal and rejection-heavy bounds.
  task automatic test_random_mix(input int n_words);
    req_t r;
    int pick;
    for (int i = 0; i < n_words; i++) begin
      idle_en = !(i >= n_words / 3 && i < n_words / 3 + 300);
      pick = $urandom_range(99);
      if (pick < 5)       r = make_req(FN_SEED);
      else if (pick < 25) r = make_req(FN_RAW);
      else if (pick < 55) r = make_req(FN_RANGE);
      else if (pick < 80) r = make_req(FN_CHOICE);
      else if (pick < 95) r = make_req(FN_FRAC);
      else r = make_req(func_t'($urandom_range(FN_UNUSED_FIRST, FN_UNUSED_LAST)));
      if (r.func == FN_RANGE) begin
        pick = $urandom_range(99);
        if (pick < 50)
          r.range_max = r.range_min + sint_t'($urandom_range(20));
        else if (pick < 60)
          r.range_max = r.range_min - sint_t'($urandom_range(20));
      end
      if (r.func == FN_CHOICE && $urandom_range(99) < 50)
        r.choice_count = $urandom_range(1, 100);
      send_word(r);
    end
    idle_en = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int drain_cycles;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FN_SEED;
    in_ch.seed_value   = '0;
    in_ch.range_min    = '0;
    in_ch.range_max    = '0;
    in_ch.choice_count = '0;
    out_ch.ready       = 1'b0;
    foreach (ops_sent[i]) ops_sent[i] = 0;
    gen_model[0] = GEN_RST0;
    gen_model[1] = GEN_RST1;
    gen_model[2] = GEN_RST2;
    gen_model[3] = GEN_RST3;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_draws();
    test_seed_extremes();
    test_range_edges();
    test_choice_edges();
    test_unused_codes();
    test_random_mix(RANDOM_WORDS);
    in_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (pending_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      error_count += pending_results.size();
    end

    $display("Sent %0d seed, %0d raw, %0d range, %0d choice, %0d fraction words",
             ops_sent[FN_SEED], ops_sent[FN_RAW], ops_sent[FN_RANGE],
             ops_sent[FN_CHOICE], ops_sent[FN_FRAC]);
    $display("plus %0d unused-code words; %0d result words checked",
             ops_sent[5] + ops_sent[6] + ops_sent[7], results_seen);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // hard stop, well beyond the slowest legal run
  initial begin : watchdog
    #36_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/xbr_pkg.sv
hdl/xbr_ifs.sv
hdl/xoshiro256ss_bounded_random.sv
tb/sv/xoshiro256ss_bounded_random_test.sv
